>>> rtl/core/pfenc_pkg.sv
// types, constants and lookup functions for the playfair digraph encryptor
// shared by playfair_digraph_encrypt; no dependencies
`timescale 1ns / 1ps

package pfenc_pkg;

	localparam int unsigned SIDE = 5;

	typedef logic [4:0] letter_t;
	typedef logic [2:0] coord_t;
	typedef logic [SIDE-1:0][SIDE-1:0][4:0] square_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} pos_t;

	typedef struct packed {
		letter_t second;
		letter_t first;
	} digraph_t;

	localparam letter_t PAD_LETTER = 5'd23;
	localparam letter_t LETTER_J   = 5'd9;
	localparam letter_t LETTER_I   = 5'd8;

	localparam logic [2:0] CFG_ROW_LAST = 3'd4;

	// a b c d e / f g h i k / l m n o p / q r s t u / v w w x z
	localparam square_t SQUARE_RESET = {25'd26991317, 25'd21613104, 25'd16201099,
		25'd10755269, 25'd4294688};

	function automatic coord_t next_coord(coord_t v);
		return (v == coord_t'(SIDE - 1)) ? '0 : coord_t'(v + 3'd1);
	endfunction

	// first match in row-major order wins; no match gives row 0, column 0
	function automatic pos_t locate(square_t sq, letter_t letter);
		pos_t p;
		p = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (sq[r][c] == letter) begin
					p.row = coord_t'(r);
					p.col = coord_t'(c);
				end
			end
		end
		return p;
	endfunction

	function automatic digraph_t encipher(square_t sq, letter_t a, letter_t b);
		pos_t pa;
		pos_t pb;
		digraph_t d;
		pa = locate(sq, a);
		pb = locate(sq, b);
		if (pa.row == pb.row) begin
			d.first  = sq[pa.row][next_coord(pa.col)];
			d.second = sq[pb.row][next_coord(pb.col)];
		end else if (pa.col == pb.col) begin
			d.first  = sq[next_coord(pa.row)][pa.col];
			d.second = sq[next_coord(pb.row)][pb.col];
		end else begin
			d.first  = sq[pa.row][pb.col];
			d.second = sq[pb.row][pa.col];
		end
		return d;
	endfunction

endpackage

>>> rtl/core/playfair_digraph_encrypt.sv
// playfair digraph encryptor: pairing front end, key square, cipher stage
// and result buffer; depends on pfenc_pkg
`timescale 1ns / 1ps

// Usage
// s_axis carries plaintext letters (tdata[4:0], 0 = a), tlast marks the end
// of a message and flushes a held letter padded with x. m_axis returns
// ciphertext letters (tdata[4:0]); tlast is high on the last letter that an
// input transfer caused. A letter that only waits for its partner causes no
// output. The key square is written over cfg: cfg_index 0..4 selects a row,
// cfg_data holds five 5-bit codes with column 0 in the low bits; other
// indexes are ignored. Write it only while the block is idle.
// An input transfer is registered, enciphered and loaded into the result
// buffer, which drives m_axis; m_axis gives one letter per cycle while
// m_axis_tready is high. A pair gives two letters and a doubled letter at
// message end four. A held letter causes no output; a transfer that
// completes a pair waits in the input register while the result buffer
// still holds letters, so a new pair is taken while the last drains. A
// receiver stall fills the input register and s_axis_tready falls. Reset
// empties both stages, drops any held letter and loads the square a..u
// without j in rows 0 to 3 and v w w x z in row 4.
module playfair_digraph_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [4:0] plain_letter, [7:5] zero
	input  logic        s_axis_tlast,   // message_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
	output logic        m_axis_tlast,   // run_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [24:0] cfg_data
);

	pfenc_pkg::square_t square_q;

	pfenc_pkg::letter_t held_letter_q;
	logic               held_valid_q;

	// input register: up to two digraphs per transfer
	logic               valid_s1;
	logic               two_s1;
	pfenc_pkg::letter_t a0_s1, b0_s1, a1_s1, b1_s1;

	// result buffer
	logic               res_valid_q;
	logic [1:0]         res_ptr_q;
	logic [1:0]         res_last_q;
	pfenc_pkg::letter_t res_q [4];

	logic               in_xfer, out_xfer, res_done, res_load;
	pfenc_pkg::letter_t letter;
	logic               make_pair, make_two;
	pfenc_pkg::letter_t a0_d, b0_d;
	logic               held_valid_d;
	pfenc_pkg::digraph_t d0, d1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q <= pfenc_pkg::SQUARE_RESET;
		end else if (cfg_valid && cfg_index <= pfenc_pkg::CFG_ROW_LAST) begin
			square_q[cfg_index] <= cfg_data;
		end
	end

	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign res_done = out_xfer && (res_ptr_q == res_last_q);
	assign res_load = valid_s1 && (!res_valid_q || res_done);
	assign s_axis_tready = !valid_s1 || res_load;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// j folds to i on arrival
	assign letter = (s_axis_tdata[4:0] == pfenc_pkg::LETTER_J) ?
		pfenc_pkg::LETTER_I : s_axis_tdata[4:0];

	always_comb begin
		make_pair    = 1'b0;
		make_two     = 1'b0;
		a0_d         = letter;
		b0_d         = pfenc_pkg::PAD_LETTER;
		held_valid_d = held_valid_q;
		if (!held_valid_q) begin
			if (s_axis_tlast) begin
				make_pair = 1'b1;
			end else begin
				held_valid_d = 1'b1;
			end
		end else if (held_letter_q == letter) begin
			// doubled letter: first copy padded, second starts the next pair or, at message end, is padded too
			make_pair = 1'b1;
			a0_d      = held_letter_q;
			if (s_axis_tlast) begin
				make_two     = 1'b1;
				held_valid_d = 1'b0;
			end
		end else begin
			make_pair    = 1'b1;
			a0_d         = held_letter_q;
			b0_d         = letter;
			held_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			held_letter_q <= '0;
		end else if (in_xfer) begin
			held_valid_q  <= held_valid_d;
			held_letter_q <= held_valid_d ? letter : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= make_pair;
		end else if (res_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			two_s1 <= make_two;
			a0_s1  <= a0_d;
			b0_s1  <= b0_d;
			a1_s1  <= letter;
			b1_s1  <= pfenc_pkg::PAD_LETTER;
		end
	end

	assign d0 = pfenc_pkg::encipher(square_q, a0_s1, b0_s1);
	assign d1 = pfenc_pkg::encipher(square_q, a1_s1, b1_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_ptr_q   <= '0;
			res_last_q  <= '0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
			res_ptr_q   <= '0;
			res_last_q  <= two_s1 ? 2'd3 : 2'd1;
		end else if (res_done) begin
			res_valid_q <= 1'b0;
		end else if (out_xfer) begin
			res_ptr_q <= res_ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q[0] <= d0.first;
			res_q[1] <= d0.second;
			res_q[2] <= d1.first;
			res_q[3] <= d1.second;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {3'b000, res_q[res_ptr_q]};
	assign m_axis_tlast  = (res_ptr_q == res_last_q);

endmodule
